// ----- src/pbi_pkg.sv -----
package pbi_pkg;

    // Fixed widths of the item fields and configuration registers.
    localparam int FIELD_BITS     = 32;
    localparam int CFG_BITS       = 32;
    localparam int REG_INDEX_BITS = 3;

    // Default number format, signed Q16.16.
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int FRAC_BITS_DEFAULT = 16;

    // Width of one multiplicand digit fed to the shared multiplier per cycle.
    localparam int MUL_DIGIT_BITS = 16;

    localparam logic [CFG_BITS-1:0] TIME_STEP_RESET    = 32'd1092;
    localparam logic [CFG_BITS-1:0] INVERSE_MASS_RESET = 32'd65536;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_TIME_STEP    = 3'd0,
        REG_INVERSE_MASS = 3'd1,
        REG_START_POS_X  = 3'd2,
        REG_START_POS_Y  = 3'd3,
        REG_START_VEL_X  = 3'd4,
        REG_START_VEL_Y  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic                         mode;
        logic signed [FIELD_BITS-1:0] force_x;
        logic signed [FIELD_BITS-1:0] force_y;
    } tick_item_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] pos_x;
        logic signed [FIELD_BITS-1:0] pos_y;
        logic signed [FIELD_BITS-1:0] vel_x;
        logic signed [FIELD_BITS-1:0] vel_y;
        logic                         saturated;
    } report_item_t;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_DIGIT,
        MUL_ROUND,
        MUL_CLIP,
        MUL_DONE
    } mul_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_UPDATE,
        ST_RESULT
    } step_state_t;

    // Which of the three products of one axis is being formed.
    typedef enum logic [1:0] {
        OP_ACCEL,
        OP_DELTA,
        OP_FINAL
    } op_t;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_status_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic sat;
    } step_status_t;

    typedef struct packed {
        logic pos_x;
        logic pos_y;
        logic vel_x;
        logic vel_y;
    } cfg_load_t;

endpackage

// ----- src/pbi_stream_if.sv -----
interface pbi_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ----- src/pbi_mul.sv -----
module pbi_mul #(
    parameter int WORD_BITS = pbi_pkg::WORD_BITS_DEFAULT,
    parameter int FRAC_BITS = pbi_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [WORD_BITS-1:0]        a,
    input  logic [pbi_pkg::CFG_BITS-1:0]       b,
    output pbi_pkg::mul_status_t               status,
    output logic signed [WORD_BITS-1:0]        product
);

    localparam int DIG   = pbi_pkg::MUL_DIGIT_BITS;
    localparam int BW    = pbi_pkg::CFG_BITS;
    localparam int NDIG  = (WORD_BITS + DIG - 1) / DIG;
    localparam int MAGW  = NDIG * DIG;
    localparam int PW    = MAGW + BW;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NDIG - 1);
    localparam logic [PW-1:0]    BIAS     = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [PW-1:0]    POS_LIM  = (PW'(1) << (WORD_BITS - 1)) - PW'(1);
    localparam logic [PW-1:0]    NEG_LIM  = PW'(1) << (WORD_BITS - 1);
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    pbi_pkg::mul_state_t state_reg, state_next;

    logic [CNT_W-1:0]            cnt_reg;
    logic                        neg_reg;
    logic [MAGW-1:0]             mag_reg;
    logic [BW-1:0]               b_reg;
    logic [PW-1:0]               acc_reg;
    logic signed [WORD_BITS-1:0] res_reg;
    logic                        sat_reg;

    logic                        load;
    logic [WORD_BITS-1:0]        a_mag;
    logic [DIG+BW-1:0]           pp;
    logic [PW-1:0]               acc_next;
    logic [PW-1:0]               qm;
    logic [WORD_BITS-1:0]        q_w;
    logic                        over;
    logic signed [WORD_BITS-1:0] res_next;

    // The magnitude of the most negative word still fits the unsigned word.
    assign a_mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;

    // Most significant digit first: shift the partial sum up, add the new row.
    assign pp       = mag_reg[MAGW-1 -: DIG] * b_reg;
    assign acc_next = (acc_reg << DIG) + PW'(pp);

    assign qm       = acc_reg >> FRAC_BITS;
    assign q_w      = qm[WORD_BITS-1:0];
    assign over     = neg_reg ? (qm > NEG_LIM) : (qm > POS_LIM);
    assign res_next = over ? (neg_reg ? WMIN : WMAX)
                           : (neg_reg ? WORD_BITS'(~q_w + 1'b1) : q_w);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbi_pkg::MUL_IDLE,
            pbi_pkg::MUL_DONE:
            begin
                if (start)
                begin
                    state_next = pbi_pkg::MUL_DIGIT;
                end
                else
                begin
                    state_next = pbi_pkg::MUL_IDLE;
                end
            end
            pbi_pkg::MUL_DIGIT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = pbi_pkg::MUL_ROUND;
                end
            end
            pbi_pkg::MUL_ROUND:
            begin
                state_next = pbi_pkg::MUL_CLIP;
            end
            pbi_pkg::MUL_CLIP:
            begin
                state_next = pbi_pkg::MUL_DONE;
            end
            default:
            begin
                state_next = pbi_pkg::MUL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load        = start && ((state_reg == pbi_pkg::MUL_IDLE) ||
                                (state_reg == pbi_pkg::MUL_DONE));
        status.done = (state_reg == pbi_pkg::MUL_DONE);
        status.sat  = sat_reg;
        product     = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbi_pkg::MUL_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                cnt_reg <= CNT_LAST;
            end
            else if (state_reg == pbi_pkg::MUL_DIGIT)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= a[WORD_BITS-1];
            mag_reg <= MAGW'(a_mag);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                pbi_pkg::MUL_DIGIT:
                begin
                    acc_reg <= acc_next;
                    mag_reg <= mag_reg << DIG;
                end
                pbi_pkg::MUL_ROUND:
                begin
                    // Floor of a negative quotient: round the magnitude up.
                    if (neg_reg)
                    begin
                        acc_reg <= acc_reg + BIAS;
                    end
                end
                pbi_pkg::MUL_CLIP:
                begin
                    res_reg <= res_next;
                    sat_reg <= over;
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == pbi_pkg::MUL_IDLE || state_reg == pbi_pkg::MUL_DONE))
        else $error("multiplier started while a product is still being formed");
`endif

endmodule

// ----- src/pbi_step.sv -----
module pbi_step #(
    parameter int WORD_BITS = pbi_pkg::WORD_BITS_DEFAULT,
    parameter int FRAC_BITS = pbi_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  pbi_pkg::tick_item_t                    item,
    input  logic [pbi_pkg::CFG_BITS-1:0]           time_step,
    input  logic [pbi_pkg::CFG_BITS-1:0]           inverse_mass,
    input  pbi_pkg::cfg_load_t                     cfg_load,
    input  logic signed [pbi_pkg::CFG_BITS-1:0]    cfg_value,
    input  logic                                   out_free,
    output pbi_pkg::step_status_t                  status,
    output logic signed [WORD_BITS-1:0]            pos_x,
    output logic signed [WORD_BITS-1:0]            pos_y,
    output logic signed [WORD_BITS-1:0]            vel_x,
    output logic signed [WORD_BITS-1:0]            vel_y
);

    localparam int FB = pbi_pkg::FIELD_BITS;
    localparam int EW = (WORD_BITS > FB) ? WORD_BITS : FB;
    localparam int SW = WORD_BITS + 2;

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Clipping of a 32-bit field into the word range.
    function automatic logic over_in(input logic signed [FB-1:0] v);
        return (EW'(v) > EW'(WMAX)) || (EW'(v) < EW'(WMIN));
    endfunction

    function automatic logic signed [WORD_BITS-1:0] clip_in(input logic signed [FB-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > EW'(WMAX))
        begin
            return WMAX;
        end
        else if (e < EW'(WMIN))
        begin
            return WMIN;
        end
        return WORD_BITS'(e);
    endfunction

    // Clipping of an exact sum into the word range.
    function automatic logic over_sum(input logic signed [SW-1:0] v);
        return (v > SW'(WMAX)) || (v < SW'(WMIN));
    endfunction

    function automatic logic signed [WORD_BITS-1:0] clip_sum(input logic signed [SW-1:0] v);
        if (v > SW'(WMAX))
        begin
            return WMAX;
        end
        else if (v < SW'(WMIN))
        begin
            return WMIN;
        end
        return WORD_BITS'(v);
    endfunction

    pbi_pkg::step_state_t state_reg, state_next;
    pbi_pkg::op_t         op_reg;
    logic                 axis_reg;
    logic                 sat_reg;
    logic                 verlet_reg;

    logic signed [WORD_BITS-1:0] pos_reg  [2];
    logic signed [WORD_BITS-1:0] prev_reg [2];
    logic signed [WORD_BITS-1:0] vel_reg  [2];
    logic signed [WORD_BITS-1:0] fx_reg;
    logic signed [WORD_BITS-1:0] fy_reg;
    logic signed [WORD_BITS-1:0] t_reg;

    logic                           mul_start;
    logic signed [WORD_BITS-1:0]    mul_a;
    logic [pbi_pkg::CFG_BITS-1:0]   mul_b;
    pbi_pkg::mul_status_t           mul_status;
    logic signed [WORD_BITS-1:0]    mul_product;

    logic signed [WORD_BITS-1:0] force_sel;
    logic signed [WORD_BITS-1:0] old_pos;
    logic signed [SW-1:0]        vel_sum;
    logic signed [SW-1:0]        pos_sum;
    logic                        force_over;

    pbi_mul #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_status),
        .product (mul_product)
    );

    assign force_sel  = axis_reg ? fy_reg : fx_reg;
    assign old_pos    = pos_reg[axis_reg];
    assign vel_sum    = SW'(vel_reg[axis_reg]) + SW'(t_reg);
    // Position Verlet forms 2p - p_prev + a*dt*dt exactly and clips once.
    assign pos_sum    = verlet_reg ? ((SW'(old_pos) <<< 1) - SW'(prev_reg[axis_reg]) + SW'(t_reg))
                                   : (SW'(old_pos) + SW'(t_reg));
    assign force_over = over_in(item.force_x) || over_in(item.force_y);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pbi_pkg::ST_ISSUE;
                end
            end
            pbi_pkg::ST_ISSUE:
            begin
                state_next = pbi_pkg::ST_WAIT;
            end
            pbi_pkg::ST_WAIT:
            begin
                if (mul_status.done)
                begin
                    if (op_reg == pbi_pkg::OP_ACCEL ||
                        (op_reg == pbi_pkg::OP_DELTA && verlet_reg))
                    begin
                        state_next = pbi_pkg::ST_ISSUE;
                    end
                    else
                    begin
                        state_next = pbi_pkg::ST_UPDATE;
                    end
                end
            end
            pbi_pkg::ST_UPDATE:
            begin
                if (op_reg == pbi_pkg::OP_DELTA || !axis_reg)
                begin
                    state_next = pbi_pkg::ST_ISSUE;
                end
                else
                begin
                    state_next = pbi_pkg::ST_RESULT;
                end
            end
            pbi_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = pbi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mul_start = (state_reg == pbi_pkg::ST_ISSUE);
        if (op_reg == pbi_pkg::OP_ACCEL)
        begin
            mul_a = force_sel;
            mul_b = inverse_mass;
        end
        else if (op_reg == pbi_pkg::OP_FINAL && !verlet_reg)
        begin
            mul_a = vel_reg[axis_reg];
            mul_b = time_step;
        end
        else
        begin
            mul_a = t_reg;
            mul_b = time_step;
        end
        status.idle = (state_reg == pbi_pkg::ST_IDLE);
        status.done = (state_reg == pbi_pkg::ST_RESULT) && out_free;
        status.sat  = sat_reg;
        pos_x       = pos_reg[0];
        pos_y       = pos_reg[1];
        vel_x       = vel_reg[0];
        vel_y       = vel_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbi_pkg::ST_IDLE;
            op_reg    <= pbi_pkg::OP_ACCEL;
            axis_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            pos_reg   <= '{default: '0};
            prev_reg  <= '{default: '0};
            vel_reg   <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                pbi_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg   <= pbi_pkg::OP_ACCEL;
                        axis_reg <= 1'b0;
                        sat_reg  <= force_over;
                    end
                end
                pbi_pkg::ST_WAIT:
                begin
                    if (mul_status.done)
                    begin
                        sat_reg <= sat_reg | mul_status.sat;
                        if (op_reg == pbi_pkg::OP_ACCEL)
                        begin
                            op_reg <= pbi_pkg::OP_DELTA;
                        end
                        else if (op_reg == pbi_pkg::OP_DELTA && verlet_reg)
                        begin
                            op_reg <= pbi_pkg::OP_FINAL;
                        end
                    end
                end
                pbi_pkg::ST_UPDATE:
                begin
                    if (op_reg == pbi_pkg::OP_DELTA)
                    begin
                        // Semi-implicit Euler updates velocity before position.
                        vel_reg[axis_reg] <= clip_sum(vel_sum);
                        sat_reg           <= sat_reg | over_sum(vel_sum);
                        op_reg            <= pbi_pkg::OP_FINAL;
                    end
                    else
                    begin
                        pos_reg[axis_reg]  <= clip_sum(pos_sum);
                        prev_reg[axis_reg] <= old_pos;
                        sat_reg            <= sat_reg | over_sum(pos_sum);
                        op_reg             <= pbi_pkg::OP_ACCEL;
                        axis_reg           <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Start values load position and previous position together.
            if (cfg_load.pos_x)
            begin
                pos_reg[0]  <= clip_in(cfg_value);
                prev_reg[0] <= clip_in(cfg_value);
            end
            if (cfg_load.pos_y)
            begin
                pos_reg[1]  <= clip_in(cfg_value);
                prev_reg[1] <= clip_in(cfg_value);
            end
            if (cfg_load.vel_x)
            begin
                vel_reg[0] <= clip_in(cfg_value);
            end
            if (cfg_load.vel_y)
            begin
                vel_reg[1] <= clip_in(cfg_value);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pbi_pkg::ST_IDLE && start)
        begin
            verlet_reg <= item.mode;
            fx_reg     <= clip_in(item.force_x);
            fy_reg     <= clip_in(item.force_y);
        end
        if (state_reg == pbi_pkg::ST_WAIT && mul_status.done)
        begin
            t_reg <= mul_product;
        end
    end

endmodule

// ----- src/planar_body_integrator_core.sv -----
// Advances one 2D point body by one tick for every item taken on the tick
// channel and returns the new position, the velocity and a saturation flag on
// the report channel. Mode 0 runs semi-implicit Euler, mode 1 position Verlet;
// arithmetic is signed fixed point of WORD_BITS bits with FRAC_BITS fraction
// bits, clipped at the word range. All six products of a tick pass through one
// shared multiplier that takes a 16-bit digit of the multiplicand per cycle.
// The tick channel is ready only while no item is in progress; a finished
// result waits in the output register while the next item is already being
// worked on. Writing a start position loads both the current and the previous
// position of that component; configuration is meant to be written while the
// block is idle.
module planar_body_integrator_core #(
    parameter int WORD_BITS = pbi_pkg::WORD_BITS_DEFAULT,
    parameter int FRAC_BITS = pbi_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    pbi_stream_if.sink                            tick,
    pbi_stream_if.source                          report,
    input  logic                                  wr_en,
    input  logic [pbi_pkg::REG_INDEX_BITS-1:0]    wr_index,
    input  logic [pbi_pkg::CFG_BITS-1:0]          wr_data
);

    localparam int FB = pbi_pkg::FIELD_BITS;
    localparam int OW = (WORD_BITS > FB) ? WORD_BITS : FB;

    localparam logic signed [FB-1:0] F32MAX = {1'b0, {(FB-1){1'b1}}};
    localparam logic signed [FB-1:0] F32MIN = {1'b1, {(FB-1){1'b0}}};

    // A word wider than the output field is clipped on its way out only.
    function automatic logic over_out(input logic signed [WORD_BITS-1:0] v);
        return (OW'(v) > OW'(F32MAX)) || (OW'(v) < OW'(F32MIN));
    endfunction

    function automatic logic signed [FB-1:0] clip_out(input logic signed [WORD_BITS-1:0] v);
        logic signed [OW-1:0] e;
        e = OW'(v);
        if (e > OW'(F32MAX))
        begin
            return F32MAX;
        end
        else if (e < OW'(F32MIN))
        begin
            return F32MIN;
        end
        return FB'(e);
    endfunction

    logic [pbi_pkg::CFG_BITS-1:0] time_step_reg;
    logic [pbi_pkg::CFG_BITS-1:0] inverse_mass_reg;
    logic                         out_valid_reg;
    pbi_pkg::report_item_t        out_data_reg;

    pbi_pkg::cfg_load_t    cfg_load;
    pbi_pkg::step_status_t step_status;
    pbi_pkg::report_item_t result;
    logic                  out_free;
    logic                  accept;

    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;

    assign accept   = tick.valid && tick.ready;
    assign out_free = !out_valid_reg || report.ready;

    assign tick.ready   = step_status.idle;
    assign report.valid = out_valid_reg;
    assign report.data  = out_data_reg;

    always_comb
    begin
        cfg_load = '0;
        if (wr_en)
        begin
            unique case (wr_index)
                pbi_pkg::REG_START_POS_X: cfg_load.pos_x = 1'b1;
                pbi_pkg::REG_START_POS_Y: cfg_load.pos_y = 1'b1;
                pbi_pkg::REG_START_VEL_X: cfg_load.vel_x = 1'b1;
                pbi_pkg::REG_START_VEL_Y: cfg_load.vel_y = 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        result.pos_x     = clip_out(pos_x);
        result.pos_y     = clip_out(pos_y);
        result.vel_x     = clip_out(vel_x);
        result.vel_y     = clip_out(vel_y);
        result.saturated = step_status.sat | over_out(pos_x) | over_out(pos_y) |
                           over_out(vel_x) | over_out(vel_y);
    end

    pbi_step #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .item         (tick.data),
        .time_step    (time_step_reg),
        .inverse_mass (inverse_mass_reg),
        .cfg_load     (cfg_load),
        .cfg_value    (wr_data),
        .out_free     (out_free),
        .status       (step_status),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= pbi_pkg::TIME_STEP_RESET;
            inverse_mass_reg <= pbi_pkg::INVERSE_MASS_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_index == pbi_pkg::REG_TIME_STEP)
            begin
                time_step_reg <= wr_data;
            end
            if (wr_en && wr_index == pbi_pkg::REG_INVERSE_MASS)
            begin
                inverse_mass_reg <= wr_data;
            end
            if (step_status.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_status.done)
        begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step_status.done |-> (!out_valid_reg || report.ready))
        else $error("result written over an item still waiting on the report channel");
`endif

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !tick.ready)
        else $error("tick channel ready again straight after accepting an item");
`endif

endmodule
